// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk with reset arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/nbm_pkg.sv =====
package nbm_pkg;

	localparam int MAX_INPUTS = 64;
	localparam int DATA_W = 16;
	localparam int IDX_W = $clog2(MAX_INPUTS);
	localparam int CNT_W = $clog2(MAX_INPUTS + 3);
	localparam int ACC_W = 40;
	localparam int FRAC = 12;
	// two slots of the update pipeline sit in the ring with the cells
	localparam int RING_LEN = MAX_INPUTS + 2;

	localparam logic [2:0] CMD_LOAD = 3'd0;
	localparam logic [2:0] CMD_FWD = 3'd1;
	localparam logic [2:0] CMD_TARGET = 3'd2;
	localparam logic [2:0] CMD_HIDDEN = 3'd3;
	localparam logic [2:0] CMD_UPDATE = 3'd4;

	localparam logic [1:0] REG_ACTIVE = 2'd0;
	localparam logic [1:0] REG_RATE = 2'd1;
	localparam logic [1:0] REG_MOMENTUM = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ACC,
		S_TANH,
		S_DER,
		S_GRAD,
		S_UPD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] w;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] d;
	} cell_t;

	typedef struct packed {
		logic shift;
		logic wr_w;
		logic wr_x;
	} cell_ctl_t;

	function automatic logic signed [DATA_W-1:0] sat_d(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd32767;
		lo = -64'sd32768;
		if (v > hi) begin
			return 16'sh7fff;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[DATA_W-1:0];
	endfunction

	function automatic logic [12:0] tanh_tab(input logic [4:0] k);
		logic [12:0] r;
		case (k)
			5'd0: r = 13'd0;
			5'd1: r = 13'd1003;
			5'd2: r = 13'd1893;
			5'd3: r = 13'd2602;
			5'd4: r = 13'd3119;
			5'd5: r = 13'd3475;
			5'd6: r = 13'd3707;
			5'd7: r = 13'd3856;
			5'd8: r = 13'd3949;
			5'd9: r = 13'd4006;
			5'd10: r = 13'd4041;
			5'd11: r = 13'd4062;
			5'd12: r = 13'd4076;
			5'd13: r = 13'd4084;
			5'd14: r = 13'd4089;
			5'd15: r = 13'd4091;
			default: r = 13'd4093;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/neuron_backprop_momentum_unit.sv =====
// States, input transfer to result register: load and unknown commands EXEC, DONE;
// forward/hidden element EXEC, ACC, DONE; last forward EXEC, ACC, TANH, DONE; target
// EXEC, DER, GRAD, DONE; last hidden EXEC, ACC, DER, GRAD, DONE. Update: EXEC, then
// UPD while the weight ring rotates once through the update pipeline, then DONE.
// One item in work at a time; the next transfer can come in the cycle after
// the result is registered. Reset: deltas, accumulator, output, gradient cleared.
`include "assert_macros.svh"

module neuron_backprop_momentum_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        command,
	input  logic [5:0]                        index,
	input  logic signed [15:0]                value,
	input  logic signed [15:0]                second_value,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                output_value,
	output logic signed [15:0]                gradient,
	output logic                              done_res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [15:0]                       cfg_data
);

	localparam int N = nbm_pkg::MAX_INPUTS;
	localparam int DW = nbm_pkg::DATA_W;

	nbm_pkg::state_t state_q, state_d;

	logic [6:0]  active_q;
	logic [15:0] eta_q;
	logic [15:0] alpha_q;
	logic [6:0]  n_act;

	logic [2:0]  cmd_q;
	logic [nbm_pkg::IDX_W-1:0] idx_q;
	logic signed [DW-1:0] val_q;
	logic signed [DW-1:0] val2_q;
	logic        last_q;

	logic signed [31:0] prod_q;
	logic        en_q;
	logic signed [nbm_pkg::ACC_W-1:0] acc_q;
	logic signed [nbm_pkg::ACC_W:0]   acc_sum;
	logic signed [nbm_pkg::ACC_W-1:0] acc_sat;
	logic signed [16:0] x_q;
	logic signed [19:0] der_q;
	logic signed [DW-1:0] out_q;
	logic signed [DW-1:0] grad_q;
	logic        done_q;
	logic [nbm_pkg::CNT_W-1:0] cnt_q;

	logic        out_valid_q;
	logic signed [DW-1:0] oval_q;
	logic signed [DW-1:0] ograd_q;
	logic        odone_q;
	logic        out_load;

	logic        wr_w;
	logic        wr_x;
	logic        shift;
	logic        in_range;
	logic        in_upd;
	logic        upd_last;

	nbm_pkg::cell_t     cq [N];
	nbm_pkg::cell_ctl_t cctl [N];
	nbm_pkg::cell_t     tail;
	logic signed [DW-1:0] w_sel;

	// tanh by table interpolation
	logic [16:0] t_abs;
	logic [12:0] t_lo;
	logic [12:0] t_hi;
	logic [9:0]  t_diff;
	logic [19:0] t_prod;
	logic [12:0] t_mag;
	logic signed [DW-1:0] t_out;

	assign n_act = (active_q == 7'd0) ? 7'd1 :
		((active_q > 7'(N)) ? 7'(N) : active_q);
	assign in_range = {1'b0, idx_q} < n_act;
	assign cfg_ready = 1'b1;
	assign w_sel = cq[idx_q].w;
	assign in_upd = state_q == nbm_pkg::S_UPD;
	assign upd_last = in_upd && cnt_q == nbm_pkg::CNT_W'(nbm_pkg::RING_LEN - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 7'd64;
			eta_q    <= 16'd9830;
			alpha_q  <= 16'd32768;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				nbm_pkg::REG_ACTIVE:   active_q <= cfg_data[6:0];
				nbm_pkg::REG_RATE:     eta_q <= cfg_data;
				nbm_pkg::REG_MOMENTUM: alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nbm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		wr_w     = 1'b0;
		wr_x     = 1'b0;
		shift    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			nbm_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = nbm_pkg::S_EXEC;
				end
			end
			nbm_pkg::S_EXEC: begin
				case (cmd_q)
					nbm_pkg::CMD_LOAD: begin
						wr_w    = 1'b1;
						state_d = nbm_pkg::S_DONE;
					end
					nbm_pkg::CMD_FWD: begin
						wr_x    = in_range;
						state_d = nbm_pkg::S_ACC;
					end
					nbm_pkg::CMD_TARGET: state_d = nbm_pkg::S_DER;
					nbm_pkg::CMD_HIDDEN: state_d = nbm_pkg::S_ACC;
					nbm_pkg::CMD_UPDATE: state_d = nbm_pkg::S_UPD;
					default: state_d = nbm_pkg::S_DONE;
				endcase
			end
			nbm_pkg::S_ACC: begin
				if (!last_q) begin
					state_d = nbm_pkg::S_DONE;
				end else if (cmd_q == nbm_pkg::CMD_FWD) begin
					state_d = nbm_pkg::S_TANH;
				end else begin
					state_d = nbm_pkg::S_DER;
				end
			end
			nbm_pkg::S_TANH: state_d = nbm_pkg::S_DONE;
			nbm_pkg::S_DER:  state_d = nbm_pkg::S_GRAD;
			nbm_pkg::S_GRAD: state_d = nbm_pkg::S_DONE;
			nbm_pkg::S_UPD: begin
				shift = 1'b1;
				if (cnt_q == nbm_pkg::CNT_W'(nbm_pkg::RING_LEN - 1)) begin
					state_d = nbm_pkg::S_DONE;
				end
			end
			nbm_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = nbm_pkg::S_IDLE;
				end
			end
			default: state_d = nbm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q  <= command;
			idx_q  <= index;
			val_q  <= value;
			val2_q <= second_value;
			last_q <= last;
		end
		if (state_q == nbm_pkg::S_EXEC) begin
			if (cmd_q == nbm_pkg::CMD_FWD) begin
				prod_q <= val_q * w_sel;
				en_q   <= in_range;
			end else begin
				prod_q <= val_q * val2_q;
				en_q   <= 1'b1;
			end
		end
		if (state_q == nbm_pkg::S_EXEC) begin
			x_q <= 17'(val_q) - 17'(out_q);
		end else if (state_q == nbm_pkg::S_ACC) begin
			x_q <= 17'(nbm_pkg::sat_d(64'(acc_sum >>> nbm_pkg::FRAC)));
		end
		if (state_q == nbm_pkg::S_DER) begin
			der_q <= 20'sd4096 - 20'((32'(out_q) * 32'(out_q)) >>> nbm_pkg::FRAC);
		end
	end

	assign acc_sum = 41'(acc_q) + (en_q ? 41'(prod_q) : 41'sd0);
	assign acc_sat = (acc_sum > 41'sh7f_ffff_ffff) ? 40'sh7f_ffff_ffff :
		(acc_sum < -41'sh80_0000_0000) ? 40'sh80_0000_0000 :
		acc_sum[nbm_pkg::ACC_W-1:0];

	assign t_abs  = x_q[16] ? -x_q : x_q;
	assign t_lo   = nbm_pkg::tanh_tab({1'b0, t_abs[13:10]});
	assign t_hi   = nbm_pkg::tanh_tab(5'({1'b0, t_abs[13:10]}) + 5'd1);
	assign t_diff = 10'(t_hi - t_lo);
	assign t_prod = 20'(t_diff) * 20'(t_abs[9:0]);
	assign t_mag  = (t_abs >= 17'd16384) ? nbm_pkg::tanh_tab(5'd16) :
		13'(t_lo + 13'(t_prod >> 10));
	assign t_out  = x_q[16] ? -DW'($signed({3'b000, t_mag})) : DW'($signed({3'b000, t_mag}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			out_q  <= '0;
			grad_q <= '0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			case (state_q)
				nbm_pkg::S_EXEC: begin
					done_q <= 1'b0;
					cnt_q  <= '0;
				end
				nbm_pkg::S_ACC: begin
					if (last_q) begin
						acc_q  <= '0;
						done_q <= 1'b1;
					end else begin
						acc_q <= acc_sat;
					end
				end
				nbm_pkg::S_TANH: out_q <= t_out;
				nbm_pkg::S_GRAD: grad_q <= nbm_pkg::sat_d(64'((37'(x_q) * 37'(der_q))
					>>> nbm_pkg::FRAC));
				nbm_pkg::S_UPD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == nbm_pkg::CNT_W'(nbm_pkg::RING_LEN - 1)) begin
						done_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// result register; a new item may transfer in while it waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			oval_q  <= out_q;
			ograd_q <= grad_q;
			odone_q <= done_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign output_value = oval_q;
	assign gradient     = ograd_q;
	assign done_res     = odone_q;

	// ring of cells: cell i hands to i-1, cell 0 feeds the update pipe,
	// which writes back into the last cell
	for (genvar i = 0; i < N; i++) begin : g_cell
		assign cctl[i].shift = shift;
		assign cctl[i].wr_w  = wr_w && (idx_q == nbm_pkg::IDX_W'(i));
		assign cctl[i].wr_x  = wr_x && (idx_q == nbm_pkg::IDX_W'(i));
		nbm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cctl[i]),
			.wdata  (val_q),
			.din    ((i == N - 1) ? tail : cq[(i + 1) % N]),
			.q      (cq[i])
		);
	end

	nbm_upd u_upd (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (shift),
		.en     (7'(cnt_q) < n_act),
		.head   (cq[0]),
		.grad   (grad_q),
		.eta    (eta_q),
		.alpha  (alpha_q),
		.tail   (tail)
	);

	`ASSERT_CLK(a_upd_len, in_upd |-> cnt_q < nbm_pkg::CNT_W'(nbm_pkg::RING_LEN), "ring overrun")
	`ASSERT_NEXT(a_upd_end, upd_last, state_q == nbm_pkg::S_DONE && done_q, "update unfinished")
	`ASSERT_CLK(a_out_src, $rose(out_valid) |-> $past(state_q) == nbm_pkg::S_DONE, "stray result")

endmodule

// ===== rtl/core/nbm_cell.sv =====
module nbm_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nbm_pkg::cell_ctl_t              ctl,
	input  logic signed [nbm_pkg::DATA_W-1:0] wdata,
	input  nbm_pkg::cell_t                  din,
	output nbm_pkg::cell_t                  q
);

	logic signed [nbm_pkg::DATA_W-1:0] w_q;
	logic signed [nbm_pkg::DATA_W-1:0] x_q;
	logic signed [nbm_pkg::DATA_W-1:0] d_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			w_q <= din.w;
			x_q <= din.x;
		end else begin
			if (ctl.wr_w) begin
				w_q <= wdata;
			end
			if (ctl.wr_x) begin
				x_q <= wdata;
			end
		end
	end

	// deltas start at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else if (ctl.shift) begin
			d_q <= din.d;
		end
	end

	assign q = {w_q, x_q, d_q};

endmodule

// ===== rtl/core/nbm_upd.sv =====
module nbm_upd (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              en,
	input  nbm_pkg::cell_t                    head,
	input  logic signed [nbm_pkg::DATA_W-1:0] grad,
	input  logic [15:0]                       eta,
	input  logic [15:0]                       alpha,
	output nbm_pkg::cell_t                    tail
);

	nbm_pkg::cell_t        c_s1;
	nbm_pkg::cell_t        c_s2;
	logic                  en_s1;
	logic                  en_s2;
	logic signed [31:0]    p1_s1;
	logic signed [32:0]    p2_s1;
	logic signed [48:0]    g_s2;
	logic signed [32:0]    k_s2;
	logic signed [49:0]    gx;
	logic signed [49:0]    kx;
	logic signed [49:0]    sum;
	logic signed [nbm_pkg::DATA_W-1:0] nd;
	logic signed [nbm_pkg::DATA_W-1:0] wnew;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			en_s2 <= 1'b0;
		end else if (step) begin
			en_s1 <= en;
			en_s2 <= en_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			c_s1  <= head;
			p1_s1 <= head.x * grad;
			p2_s1 <= $signed({1'b0, alpha}) * head.d;
			c_s2  <= c_s1;
			g_s2  <= p1_s1 * $signed({1'b0, eta});
			k_s2  <= p2_s1;
		end
	end

	// delta = floor((eta*x*g + alpha*old*4096) / 2^28)
	assign gx   = 50'(g_s2);
	assign kx   = 50'(k_s2) <<< 12;
	assign sum  = gx + kx;
	assign nd   = nbm_pkg::sat_d(64'(sum >>> 28));
	assign wnew = nbm_pkg::sat_d(64'(c_s2.w) + 64'(nd));

	always_comb begin
		tail = c_s2;
		if (en_s2) begin
			tail.w = wnew;
			tail.d = nd;
		end
	end

endmodule
